FILE: src/bpes_pkg.sv
// Package for the bead percentile exposure statistics block: widths, codes,
// milestone table, controller state type and the control/status structs.
// No dependencies.
`timescale 1ns / 1ps

package bpes_pkg;

    localparam int MAX_BEADS = 16384;
    localparam int ADDR_W    = $clog2(MAX_BEADS);
    localparam int CNT_W     = ADDR_W + 1;
    localparam int VAL_W     = 16;
    localparam int SUM_W     = 30;
    localparam int PCT_W     = 7;
    localparam int DIM_W     = 13;
    localparam int CRD_W     = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int KIND_W    = 2;
    localparam int NMILE     = 12;
    localparam int PROD_W    = CNT_W + PCT_W;
    localparam int BIG_COUNT = 100;

    localparam logic [KIND_W-1:0] KIND_BEAD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MILE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SUM  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_COLS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_ROWS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_MISS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPO_PCT    = 3'd5;

    localparam logic [PCT_W-1:0] MILE_PCT [NMILE] = '{
        7'd1, 7'd2, 7'd5, 7'd10, 7'd20, 7'd30,
        7'd40, 7'd50, 7'd60, 7'd70, 7'd80, 7'd90
    };

    typedef enum logic [4:0] {
        ST_IDLE, ST_ITEM, ST_SORT_INIT, ST_M_CHK, ST_M_RD, ST_M_WR,
        ST_WALK_INIT, ST_W_RD, ST_W_ACC, ST_W_DEC, ST_EXP_S, ST_EXP_W,
        ST_PCT_S, ST_PCT_W, ST_TAV_S, ST_TAV_W, ST_BAV_S, ST_BAV_W,
        ST_MILE_OUT, ST_W_NEXT, ST_MEAN_S, ST_MEAN_W, ST_SUM_OUT
    } state_t;

    typedef enum logic [2:0] {
        DIV_EXPO, DIV_PCT, DIV_TOP, DIV_BOT, DIV_MEAN
    } div_op_t;

    typedef struct packed {
        logic    load_item;
        logic    emit_bead;
        logic    sort_init;
        logic    merge_read;
        logic    merge_write;
        logic    walk_init;
        logic    walk_read;
        logic    walk_acc;
        logic    walk_next;
        logic    div_start;
        div_op_t div_op;
        logic    emit_mile;
        logic    emit_sum;
    } cmd_t;

    typedef struct packed {
        logic item_bead;
        logic item_end;
        logic out_full;
        logic sorted;
        logic n_zero;
        logic n_mean;
        logic hit_mark;
        logic hit_expo;
        logic walk_last;
        logic div_done;
    } status_t;

endpackage

FILE: src/bpes_div.sv
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// Depends on bpes_pkg.
`timescale 1ns / 1ps

module bpes_div import bpes_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [SUM_W-1:0] dividend,
    input  logic [CNT_W-1:0] divisor,
    output logic             done,
    output logic [SUM_W-1:0] quotient
);

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0]  quo_reg, quo_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  dsr_reg;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W:0]    trial;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[SUM_W-1]};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = STEP_W'(SUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = CNT_W'(trial - {1'b0, dsr_reg});
                quo_next = {quo_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[CNT_W-1:0];
                quo_next = {quo_reg[SUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            dsr_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: src/bpes_dp.sv
// Datapath: configuration, bead value, two sort buffers, merge and walk
// pointers, sums, divider and the output register. Depends on bpes_pkg, bpes_div.
`timescale 1ns / 1ps

module bpes_dp import bpes_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic [CRD_W-1:0]     col_coord,
    input  logic [CRD_W-1:0]     row_coord,
    input  logic [VAL_W-1:0]     pixel_value,
    input  logic                 holds_bead,
    input  logic                 list_end,
    input  cmd_t                 cmd,
    output status_t              status,
    input  logic                 out_stall,
    output logic                 out_valid,
    output logic [KIND_W-1:0]    record_kind,
    output logic [VAL_W-1:0]     bead_value,
    output logic [PCT_W-1:0]     percent_label,
    output logic [ADDR_W-1:0]    rank_index,
    output logic [VAL_W-1:0]     top_average,
    output logic [VAL_W-1:0]     bottom_average,
    output logic [SUM_W-1:0]     top_sum,
    output logic [SUM_W-1:0]     bottom_sum,
    output logic [VAL_W-1:0]     exposure_value,
    output logic [CNT_W-1:0]     bead_count,
    output logic [SUM_W-1:0]     total_sum,
    output logic                 run_last
);

    localparam int EXT_W = CNT_W + 2;

    // configuration
    logic [CRD_W-1:0] offset_cols_reg, offset_rows_reg;
    logic [DIM_W-1:0] image_cols_reg, image_rows_reg;
    logic             image_missing_reg;
    logic [PCT_W-1:0] expo_pct_reg;

    // captured item
    logic [CRD_W-1:0] col_reg, row_reg;
    logic [VAL_W-1:0] pix_reg;
    logic             bead_reg, end_reg;

    // frame state
    logic [CNT_W-1:0] cnt_reg;
    logic [SUM_W-1:0] total_reg;

    // sort buffers
    logic [VAL_W-1:0]  mem_a [MAX_BEADS];
    logic [VAL_W-1:0]  mem_b [MAX_BEADS];
    logic [VAL_W-1:0]  a_rd0, a_rd1, b_rd0, b_rd1;
    logic              a_we, b_we;
    logic [ADDR_W-1:0] a_wa, wr_addr, ra0, ra1;
    logic [VAL_W-1:0]  a_wd;

    // merge control
    logic [CNT_W-1:0] lo_reg, w_reg, li_reg, ri_reg, k_reg;
    logic             src_b_reg, sorted_reg;

    // walk
    logic [ADDR_W-1:0] i_reg;
    logic [SUM_W-1:0]  top_reg, bot_reg;
    logic [PROD_W-1:0] prod_e_reg;
    logic              hit_mark_reg, hit_expo_reg, last_reg;
    logic [VAL_W-1:0]  expo_reg, tavg_reg, bavg_reg;
    logic [PCT_W-1:0]  pct_reg;
    div_op_t           div_op_reg;

    // output register
    logic              out_valid_reg;
    logic [KIND_W-1:0] kind_reg;
    logic [VAL_W-1:0]  bval_reg, oexpo_reg, otavg_reg, obavg_reg;
    logic [PCT_W-1:0]  opct_reg;
    logic [ADDR_W-1:0] orank_reg;
    logic [SUM_W-1:0]  otop_reg, obot_reg, ototal_reg;
    logic [CNT_W-1:0]  ocnt_reg;
    logic              olast_reg;

    // bead value
    logic signed [CRD_W:0] pos_x, pos_y;
    logic                  in_image, room;
    logic [VAL_W-1:0]      bval;
    logic [CNT_W-1:0]      cnt_new;
    logic [SUM_W-1:0]      total_new;

    always_comb
    begin
        pos_x = $signed({col_reg[CRD_W-1], col_reg})
              + $signed({offset_cols_reg[CRD_W-1], offset_cols_reg});
        pos_y = $signed({row_reg[CRD_W-1], row_reg})
              + $signed({offset_rows_reg[CRD_W-1], offset_rows_reg});
        in_image = !pos_x[CRD_W] && !pos_y[CRD_W]
                && (pos_x[CRD_W-1:0] < CRD_W'(image_cols_reg))
                && (pos_y[CRD_W-1:0] < CRD_W'(image_rows_reg));
        bval = '0;
        if (in_image && !image_missing_reg)
        begin
            bval = (pix_reg == '0) ? VAL_W'(1) : pix_reg;
        end
        room      = cnt_reg < CNT_W'(MAX_BEADS);
        cnt_new   = room ? cnt_reg + 1'b1 : cnt_reg;
        total_new = room ? total_reg + SUM_W'(bval) : total_reg;
    end

    // merge bounds of the current run pair
    logic [EXT_W-1:0] n_x, lo_w, lo_2w, hi_w, w2_x;
    logic [CNT_W-1:0] mid, hi, next_mid, pass_ri;
    logic [VAL_W-1:0] s_rd0, s_rd1, merge_data;
    logic             take_left;

    always_comb
    begin
        n_x      = EXT_W'(cnt_reg);
        lo_w     = EXT_W'(lo_reg) + EXT_W'(w_reg);
        lo_2w    = EXT_W'(lo_reg) + EXT_W'({w_reg, 1'b0});
        mid      = (lo_w < n_x) ? lo_w[CNT_W-1:0] : cnt_reg;
        hi       = (lo_2w < n_x) ? lo_2w[CNT_W-1:0] : cnt_reg;
        hi_w     = EXT_W'(hi) + EXT_W'(w_reg);
        next_mid = (hi_w < n_x) ? hi_w[CNT_W-1:0] : cnt_reg;
        w2_x     = EXT_W'({w_reg, 1'b0});
        pass_ri  = (w2_x < n_x) ? w2_x[CNT_W-1:0] : cnt_reg;
        s_rd0    = src_b_reg ? b_rd0 : a_rd0;
        s_rd1    = src_b_reg ? b_rd1 : a_rd1;
        take_left = (li_reg < mid) && ((ri_reg >= hi) || (s_rd0 <= s_rd1));
        merge_data = take_left ? s_rd0 : s_rd1;
    end

    // memory ports
    logic [CNT_W-1:0] rev_idx;

    always_comb
    begin
        rev_idx = cnt_reg - 1'b1 - CNT_W'(i_reg);
        ra0     = cmd.walk_read ? i_reg : li_reg[ADDR_W-1:0];
        ra1     = cmd.walk_read ? rev_idx[ADDR_W-1:0] : ri_reg[ADDR_W-1:0];
        wr_addr = k_reg[ADDR_W-1:0];
        a_we    = (cmd.emit_bead && room) || (cmd.merge_write && src_b_reg);
        a_wa    = cmd.emit_bead ? cnt_reg[ADDR_W-1:0] : wr_addr;
        a_wd    = cmd.emit_bead ? bval : merge_data;
        b_we    = cmd.merge_write && !src_b_reg;
    end

    always_ff @(posedge clk)
    begin
        if (a_we)
        begin
            mem_a[a_wa] <= a_wd;
        end
        a_rd0 <= mem_a[ra0];
        a_rd1 <= mem_a[ra1];
    end

    always_ff @(posedge clk)
    begin
        if (b_we)
        begin
            mem_b[wr_addr] <= merge_data;
        end
        b_rd0 <= mem_b[ra0];
        b_rd1 <= mem_b[ra1];
    end

    // walk rank tests: rank i is taken at percent p when 100*i <= n*p < 100*i+100
    logic [PROD_W-1:0] i100;
    logic              mile_hit, expo_hit;

    always_comb
    begin
        i100     = PROD_W'(i_reg) * PROD_W'(BIG_COUNT);
        mile_hit = (CNT_W'(i_reg) == cnt_reg - 1'b1);
        for (int m = 0; m < NMILE; m++)
        begin
            if ((i100 <= PROD_W'(cnt_reg) * PROD_W'(MILE_PCT[m]))
                && (PROD_W'(cnt_reg) * PROD_W'(MILE_PCT[m]) < i100 + PROD_W'(BIG_COUNT)))
            begin
                mile_hit = 1'b1;
            end
        end
        expo_hit = (i100 <= prod_e_reg) && (prod_e_reg < i100 + PROD_W'(BIG_COUNT));
    end

    // divider
    logic [SUM_W-1:0] div_dividend, div_q;
    logic [CNT_W-1:0] div_divisor, i_plus;
    logic             div_done;

    always_comb
    begin
        i_plus = CNT_W'(i_reg) + 1'b1;
        case (cmd.div_op)
            DIV_PCT:
            begin
                div_dividend = SUM_W'(i100);
                div_divisor  = cnt_reg;
            end
            DIV_BOT:
            begin
                div_dividend = bot_reg;
                div_divisor  = i_plus;
            end
            DIV_MEAN:
            begin
                div_dividend = bot_reg;
                div_divisor  = cnt_reg;
            end
            default:
            begin
                div_dividend = top_reg;
                div_divisor  = i_plus;
            end
        endcase
    end

    bpes_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_cols_reg   <= '0;
            offset_rows_reg   <= '0;
            image_cols_reg    <= DIM_W'(1000);
            image_rows_reg    <= DIM_W'(1000);
            image_missing_reg <= 1'b0;
            expo_pct_reg      <= PCT_W'(10);
            cnt_reg           <= '0;
            total_reg         <= '0;
            src_b_reg         <= 1'b0;
            sorted_reg        <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                case (cfg_addr)
                    CFG_OFFSET_COLS: offset_cols_reg   <= cfg_data;
                    CFG_OFFSET_ROWS: offset_rows_reg   <= cfg_data;
                    CFG_IMAGE_COLS:  image_cols_reg    <= cfg_data[DIM_W-1:0];
                    CFG_IMAGE_ROWS:  image_rows_reg    <= cfg_data[DIM_W-1:0];
                    CFG_IMAGE_MISS:  image_missing_reg <= cfg_data[0];
                    CFG_EXPO_PCT:    expo_pct_reg      <= cfg_data[PCT_W-1:0];
                    default:         ;
                endcase
            end

            if (cmd.emit_bead)
            begin
                cnt_reg   <= cnt_new;
                total_reg <= total_new;
            end
            else if (cmd.emit_sum)
            begin
                cnt_reg   <= '0;
                total_reg <= '0;
            end

            if (cmd.sort_init)
            begin
                src_b_reg  <= 1'b0;
                sorted_reg <= (cnt_reg < CNT_W'(2));
            end
            else if (cmd.merge_write && (k_reg + 1'b1 == hi) && (hi >= cnt_reg))
            begin
                src_b_reg  <= !src_b_reg;
                sorted_reg <= (w2_x >= n_x);
            end

            if (cmd.emit_bead || cmd.emit_mile || cmd.emit_sum)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            col_reg  <= col_coord;
            row_reg  <= row_coord;
            pix_reg  <= pixel_value;
            bead_reg <= holds_bead;
            end_reg  <= list_end;
        end

        if (cmd.sort_init)
        begin
            lo_reg <= '0;
            w_reg  <= CNT_W'(1);
            li_reg <= '0;
            ri_reg <= (cnt_reg != '0) ? CNT_W'(1) : '0;
            k_reg  <= '0;
        end
        else if (cmd.merge_write)
        begin
            if (k_reg + 1'b1 == hi)
            begin
                if (hi >= cnt_reg)
                begin
                    lo_reg <= '0;
                    w_reg  <= w2_x[CNT_W-1:0];
                    li_reg <= '0;
                    ri_reg <= pass_ri;
                    k_reg  <= '0;
                end
                else
                begin
                    lo_reg <= hi;
                    li_reg <= hi;
                    ri_reg <= next_mid;
                    k_reg  <= hi;
                end
            end
            else
            begin
                k_reg <= k_reg + 1'b1;
                if (take_left)
                begin
                    li_reg <= li_reg + 1'b1;
                end
                else
                begin
                    ri_reg <= ri_reg + 1'b1;
                end
            end
        end

        if (cmd.walk_init)
        begin
            i_reg      <= '0;
            top_reg    <= '0;
            bot_reg    <= '0;
            expo_reg   <= '0;
            prod_e_reg <= PROD_W'(cnt_reg) * PROD_W'(expo_pct_reg);
        end
        else
        begin
            if (cmd.walk_acc)
            begin
                top_reg      <= top_reg + SUM_W'(s_rd1);
                bot_reg      <= bot_reg + SUM_W'(s_rd0);
                hit_mark_reg <= (cnt_reg >= CNT_W'(BIG_COUNT)) && mile_hit;
                hit_expo_reg <= (cnt_reg >= CNT_W'(BIG_COUNT)) && expo_hit;
                last_reg     <= (CNT_W'(i_reg) == cnt_reg - 1'b1);
            end
            if (cmd.walk_next)
            begin
                i_reg <= i_reg + 1'b1;
            end
            if (div_done)
            begin
                case (div_op_reg)
                    DIV_EXPO: expo_reg <= div_q[VAL_W-1:0];
                    DIV_PCT:  pct_reg  <= div_q[PCT_W-1:0] + 1'b1;
                    DIV_TOP:  tavg_reg <= div_q[VAL_W-1:0];
                    DIV_BOT:  bavg_reg <= div_q[VAL_W-1:0];
                    DIV_MEAN: expo_reg <= div_q[VAL_W-1:0];
                    default:  ;
                endcase
            end
        end

        if (cmd.div_start)
        begin
            div_op_reg <= cmd.div_op;
        end

        if (cmd.emit_bead || cmd.emit_mile || cmd.emit_sum)
        begin
            kind_reg   <= KIND_BEAD;
            bval_reg   <= '0;
            opct_reg   <= '0;
            orank_reg  <= '0;
            otavg_reg  <= '0;
            obavg_reg  <= '0;
            otop_reg   <= '0;
            obot_reg   <= '0;
            oexpo_reg  <= '0;
            ocnt_reg   <= cnt_reg;
            ototal_reg <= total_reg;
            olast_reg  <= 1'b0;
            if (cmd.emit_bead)
            begin
                bval_reg   <= bval;
                ocnt_reg   <= cnt_new;
                ototal_reg <= total_new;
            end
            else if (cmd.emit_mile)
            begin
                kind_reg  <= KIND_MILE;
                opct_reg  <= pct_reg;
                orank_reg <= i_reg;
                otavg_reg <= tavg_reg;
                obavg_reg <= bavg_reg;
                otop_reg  <= top_reg;
                obot_reg  <= bot_reg;
            end
            else
            begin
                kind_reg  <= KIND_SUM;
                oexpo_reg <= expo_reg;
                olast_reg <= 1'b1;
            end
        end
    end

    assign status.item_bead = bead_reg;
    assign status.item_end  = end_reg;
    assign status.out_full  = out_valid_reg;
    assign status.sorted    = sorted_reg;
    assign status.n_zero    = (cnt_reg == '0);
    assign status.n_mean    = (cnt_reg != '0) && (cnt_reg < CNT_W'(BIG_COUNT));
    assign status.hit_mark  = hit_mark_reg;
    assign status.hit_expo  = hit_expo_reg;
    assign status.walk_last = last_reg;
    assign status.div_done  = div_done;

    assign out_valid      = out_valid_reg;
    assign record_kind    = kind_reg;
    assign bead_value     = bval_reg;
    assign percent_label  = opct_reg;
    assign rank_index     = orank_reg;
    assign top_average    = otavg_reg;
    assign bottom_average = obavg_reg;
    assign top_sum        = otop_reg;
    assign bottom_sum     = obot_reg;
    assign exposure_value = oexpo_reg;
    assign bead_count     = ocnt_reg;
    assign total_sum      = ototal_reg;
    assign run_last       = olast_reg;

endmodule

FILE: src/bpes_ctrl.sv
// Controller state machine: item intake, merge sort passes, rank walk,
// divisions and record emission. Depends on bpes_pkg.
`timescale 1ns / 1ps

module bpes_ctrl import bpes_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  status_t status,
    output cmd_t    cmd,
    output logic    in_stall
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (in_valid) state_next = ST_ITEM;
            ST_ITEM:
            begin
                if (!status.item_bead || !status.out_full)
                begin
                    state_next = status.item_end ? ST_SORT_INIT : ST_IDLE;
                end
            end
            ST_SORT_INIT: state_next = ST_M_CHK;
            ST_M_CHK:     state_next = status.sorted ? ST_WALK_INIT : ST_M_RD;
            ST_M_RD:      state_next = ST_M_WR;
            ST_M_WR:      state_next = ST_M_CHK;
            ST_WALK_INIT: state_next = status.n_zero ? ST_SUM_OUT : ST_W_RD;
            ST_W_RD:      state_next = ST_W_ACC;
            ST_W_ACC:     state_next = ST_W_DEC;
            ST_W_DEC:
            begin
                if (status.hit_expo)
                begin
                    state_next = ST_EXP_S;
                end
                else
                begin
                    state_next = status.hit_mark ? ST_PCT_S : ST_W_NEXT;
                end
            end
            ST_EXP_S:     state_next = ST_EXP_W;
            ST_EXP_W:
            begin
                if (status.div_done)
                begin
                    state_next = status.hit_mark ? ST_PCT_S : ST_W_NEXT;
                end
            end
            ST_PCT_S:     state_next = ST_PCT_W;
            ST_PCT_W:     if (status.div_done) state_next = ST_TAV_S;
            ST_TAV_S:     state_next = ST_TAV_W;
            ST_TAV_W:     if (status.div_done) state_next = ST_BAV_S;
            ST_BAV_S:     state_next = ST_BAV_W;
            ST_BAV_W:     if (status.div_done) state_next = ST_MILE_OUT;
            ST_MILE_OUT:  if (!status.out_full) state_next = ST_W_NEXT;
            ST_W_NEXT:
            begin
                if (!status.walk_last)
                begin
                    state_next = ST_W_RD;
                end
                else
                begin
                    state_next = status.n_mean ? ST_MEAN_S : ST_SUM_OUT;
                end
            end
            ST_MEAN_S:    state_next = ST_MEAN_W;
            ST_MEAN_W:    if (status.div_done) state_next = ST_SUM_OUT;
            ST_SUM_OUT:   if (!status.out_full) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.div_op = DIV_TOP;
        case (state_reg)
            ST_IDLE:      cmd.load_item = in_valid;
            ST_ITEM:      cmd.emit_bead = status.item_bead && !status.out_full;
            ST_SORT_INIT: cmd.sort_init = 1'b1;
            ST_M_RD:      cmd.merge_read = 1'b1;
            ST_M_WR:      cmd.merge_write = 1'b1;
            ST_WALK_INIT: cmd.walk_init = 1'b1;
            ST_W_RD:      cmd.walk_read = 1'b1;
            ST_W_ACC:     cmd.walk_acc = 1'b1;
            ST_EXP_S:
            begin
                cmd.div_start = 1'b1;
                cmd.div_op    = DIV_EXPO;
            end
            ST_PCT_S:
            begin
                cmd.div_start = 1'b1;
                cmd.div_op    = DIV_PCT;
            end
            ST_TAV_S:
            begin
                cmd.div_start = 1'b1;
                cmd.div_op    = DIV_TOP;
            end
            ST_BAV_S:
            begin
                cmd.div_start = 1'b1;
                cmd.div_op    = DIV_BOT;
            end
            ST_MEAN_S:
            begin
                cmd.div_start = 1'b1;
                cmd.div_op    = DIV_MEAN;
            end
            ST_MILE_OUT:  cmd.emit_mile = !status.out_full;
            ST_W_NEXT:    cmd.walk_next = !status.walk_last;
            ST_SUM_OUT:   cmd.emit_sum = !status.out_full;
            default:      ;
        endcase
    end

    assign in_stall = (state_reg != ST_IDLE);

endmodule

FILE: src/bead_percentile_exposure_stats_core.sv
// Top level of the bead percentile exposure statistics block.
// Depends on bpes_pkg, bpes_ctrl, bpes_dp (which holds bpes_div).
`timescale 1ns / 1ps
//
//   channel   handshake              payload
//   -------   ---------------------  ------------------------------------------
//   config    cfg_wr                 cfg_addr (register index), cfg_data
//   input     in_valid / in_stall    col_coord row_coord pixel_value
//                                    holds_bead list_end
//   output    out_valid / out_stall  record_kind .. run_last (twelve fields)
//
// A bead transaction is a capture, then, once the output register is free, value,
// store write and bead record into the output register. At list end the stored
// values are sorted by a bottom-up merge over two buffers, each element of a pass
// taking states M_CHK, M_RD and M_WR, in ceil(log2 n) passes, then walked through
// W_RD, W_ACC, W_DEC and W_NEXT for each rank; every milestone costs three divisions
// and the exposure rank one more, all on one shared divider. Reset clears control
// state only; buffer contents need no clearing.
// A held output record stalls the controller only where it has a new record.

module bead_percentile_exposure_stats_core import bpes_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [CRD_W-1:0]     col_coord,
    input  logic [CRD_W-1:0]     row_coord,
    input  logic [VAL_W-1:0]     pixel_value,
    input  logic                 holds_bead,
    input  logic                 list_end,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [KIND_W-1:0]    record_kind,
    output logic [VAL_W-1:0]     bead_value,
    output logic [PCT_W-1:0]     percent_label,
    output logic [ADDR_W-1:0]    rank_index,
    output logic [VAL_W-1:0]     top_average,
    output logic [VAL_W-1:0]     bottom_average,
    output logic [SUM_W-1:0]     top_sum,
    output logic [SUM_W-1:0]     bottom_sum,
    output logic [VAL_W-1:0]     exposure_value,
    output logic [CNT_W-1:0]     bead_count,
    output logic [SUM_W-1:0]     total_sum,
    output logic                 run_last
);

    cmd_t    cmd;
    status_t status;

    // sequence every transaction: intake, sort, walk, divide, emit
    bpes_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status   (status),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    // hold config, buffers, sums and the output register
    bpes_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr         (cfg_wr),
        .cfg_addr       (cfg_addr),
        .cfg_data       (cfg_data),
        .col_coord      (col_coord),
        .row_coord      (row_coord),
        .pixel_value    (pixel_value),
        .holds_bead     (holds_bead),
        .list_end       (list_end),
        .cmd            (cmd),
        .status         (status),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .record_kind    (record_kind),
        .bead_value     (bead_value),
        .percent_label  (percent_label),
        .rank_index     (rank_index),
        .top_average    (top_average),
        .bottom_average (bottom_average),
        .top_sum        (top_sum),
        .bottom_sum     (bottom_sum),
        .exposure_value (exposure_value),
        .bead_count     (bead_count),
        .total_sum      (total_sum),
        .run_last       (run_last)
    );

endmodule

FILE: src/bpes_checker.sv
// Port-level checker for the bead percentile exposure statistics core,
// bound to the top level. Depends on bpes_pkg.
`timescale 1ns / 1ps

module bpes_checker import bpes_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 out_valid,
    input logic                 out_stall,
    input logic [KIND_W-1:0]    record_kind,
    input logic [PCT_W-1:0]     percent_label,
    input logic [VAL_W-1:0]     top_average,
    input logic [VAL_W-1:0]     bottom_average,
    input logic [SUM_W-1:0]     top_sum,
    input logic [SUM_W-1:0]     bottom_sum,
    input logic [CNT_W-1:0]     bead_count,
    input logic                 run_last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output record dropped while stalled");

    a_last_only_summary: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (run_last == (record_kind == KIND_SUM)))
        else $error("run_last does not match summary record");

    a_mile_big: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && record_kind == KIND_MILE |-> bead_count >= CNT_W'(BIG_COUNT))
        else $error("milestone with fewer than 100 beads");

    a_mile_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && record_kind == KIND_MILE
        |-> top_average >= bottom_average && top_sum >= bottom_sum
            && percent_label != '0)
        else $error("milestone top below bottom");

    a_sum_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && record_kind == KIND_SUM && !out_stall |=> !out_valid || run_last == 1'b0)
        else $error("summary record repeated");

endmodule

bind bead_percentile_exposure_stats_core bpes_checker u_bpes_checker (.*);
